// ===== sv/packet_resequencer_window_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the packet resequencer window core
// Same-cycle and next-cycle implication checks, clocked on the rising edge
// and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PACKET_RESEQUENCER_WINDOW_CORE_ASSERT_SVH
`define PACKET_RESEQUENCER_WINDOW_CORE_ASSERT_SVH

// ante implies cons in the same cycle
`define PRW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prw check failed");

// ante implies cons in the next cycle
`define PRW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prw check failed");

`endif

// ===== sv/prw_pkg.sv =====
// ---------------------------------------------------------------------------
// prw_pkg
// Shared widths, codes and helpers for the packet resequencer window core.
// ---------------------------------------------------------------------------
`default_nettype none

package prw_pkg;

   localparam int SEQ_W      = 63;   // sequence number field
   localparam int STATE_W    = 64;   // internal sequence arithmetic
   localparam int SLOT_W     = 16;   // slot index field
   localparam int CNT_W      = 17;   // slot counts, fills, missing count
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] MAX_SLOTS   = 17'h10000;
   localparam logic [CNT_W-1:0] FILL_MAX    = 17'h1ffff;
   localparam logic [CNT_W-1:0] SLOTS_RESET = 17'h10000;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_SLOTS = 1'b0;
   localparam logic CSR_IDX_MODE  = 1'b1;

   typedef enum logic [1:0] {
      PLACE_CURRENT       = 2'd0,
      PLACE_PREVIOUS      = 2'd1,
      PLACE_DUPLICATE     = 2'd2,
      PLACE_OUT_OF_WINDOW = 2'd3
   } placement_type;

   // saturating fill increment
   function automatic logic [CNT_W-1:0] fill_inc(input logic [CNT_W-1:0] f);
      return (f == FILL_MAX) ? f : f + 17'd1;
   endfunction

endpackage

`default_nettype wire

// ===== sv/packet_resequencer_window_core.sv =====
// ---------------------------------------------------------------------------
// packet_resequencer_window_core
// Two-buffer reorder window: places each packet sequence number into the
// current or previous buffer, or drops it, one decision per word.
// ---------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   req      | in        | req_valid / req_stall  | seq_number
//   rsp      | out       | rsp_valid / rsp_stall  | placement, slot_index, flags,
//            |           |                        | missing_added
//   csr      | in/out    | psel/penable/pready    | slots_per_buffer, sequence_mode
//
// One word per cycle while rsp_stall does not hold the result register; a
// taken word sits in the input register, then its result is registered.
// The decision path is one pass of 64-bit adds and compares between the
// input register and the result register; window state updates as the
// result register loads.
// Reset (synchronous) closes the window and restores register defaults.
// rsp_stall holds the result register; the input register still takes one
// more word, and req_stall rises only when both are occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module packet_resequencer_window_core (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [prw_pkg::SEQ_W-1:0]           req_seq_number,
   // result channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output prw_pkg::placement_type              rsp_placement,
   output logic [prw_pkg::SLOT_W-1:0]          rsp_slot_index,
   output logic                                rsp_window_advanced,
   output logic                                rsp_retired_complete,
   output logic                                rsp_previous_released,
   output logic [prw_pkg::CNT_W-1:0]           rsp_missing_added,
   // register port
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [prw_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire  [prw_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [prw_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import prw_pkg::*;

   // configuration
   logic [CNT_W-1:0]   slots_cfg_ff;
   logic               mode_ff;
   logic               csr_write;

   // input register
   logic               in_valid_ff;
   logic [SEQ_W-1:0]   in_seq_ff;
   logic               req_take;
   logic               fire;

   // window state
   logic               started_ff,  started_in;
   logic [STATE_W-1:0] last_ff,     last_in;
   logic [STATE_W-1:0] ws_ff,       ws_in;
   logic [CNT_W-1:0]   pos_ff,      pos_in;
   logic [CNT_W-1:0]   cur_fill_ff, cur_fill_in;
   logic               prev_vld_ff, prev_vld_in;
   logic [CNT_W-1:0]   prev_fill_ff, prev_fill_in;

   // result register
   logic               rsp_valid_ff;
   placement_type      place_ff,    place_in;
   logic [SLOT_W-1:0]  slot_ff,     slot_in;
   logic               adv_ff,      adv_in;
   logic               retired_ff,  retired_in;
   logic               released_ff, released_in;
   logic [CNT_W-1:0]   missing_ff,  missing_in;

   // decision path
   logic [CNT_W-1:0]          slots;
   logic                      adv_first;
   logic [STATE_W-1:0]        last_p1;
   logic [STATE_W-1:0]        ws_p1;
   logic [STATE_W-1:0]        ws_p2;
   logic [STATE_W-1:0]        seq;
   logic signed [STATE_W-1:0] dc;
   logic signed [STATE_W-1:0] ds;
   logic signed [STATE_W-1:0] s64;
   logic signed [STATE_W-1:0] neg_s;
   logic signed [STATE_W-1:0] two_s;
   logic [CNT_W-1:0]          jump_pos;
   logic [CNT_W-1:0]          late_slot;
   logic [CNT_W:0]            miss_acc;

   // ---------------- register port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[2])
         CSR_IDX_SLOTS: prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, slots_cfg_ff};
         CSR_IDX_MODE:  prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         default:       prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   // decision fires when the input register holds a word and the result
   // register is empty or being drained this cycle
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   // ---------------- decision ----------------
   // clamp to 1 .. MAX_SLOTS
   assign slots = (slots_cfg_ff == '0)       ? {{(CNT_W-1){1'b0}}, 1'b1} :
                  (slots_cfg_ff > MAX_SLOTS) ? MAX_SLOTS : slots_cfg_ff;

   assign adv_first = (pos_ff >= slots);
   assign last_p1   = last_ff + 64'd1;
   assign ws_p1     = ws_ff + {{(STATE_W-CNT_W){1'b0}}, slots};
   assign ws_p2     = ws_p1 + {{(STATE_W-CNT_W){1'b0}}, slots};
   assign seq       = mode_ff ? last_p1 : {1'b0, in_seq_ff};
   assign s64       = signed'({{(STATE_W-CNT_W){1'b0}}, slots});
   assign neg_s     = -s64;
   assign two_s     = signed'({{(STATE_W-CNT_W-1){1'b0}}, slots, 1'b0});
   assign dc        = signed'(seq - last_ff);

   always_comb begin
      started_in   = started_ff;
      last_in      = last_ff;
      ws_in        = ws_ff;
      pos_in       = pos_ff;
      cur_fill_in  = cur_fill_ff;
      prev_vld_in  = prev_vld_ff;
      prev_fill_in = prev_fill_ff;
      adv_in       = 1'b0;
      retired_in   = 1'b0;
      released_in  = 1'b0;
      miss_acc     = '0;
      place_in     = PLACE_OUT_OF_WINDOW;
      slot_in      = '0;

      // buffer switch before placement
      if (adv_first) begin
         adv_in = 1'b1;
         if (prev_vld_ff) begin
            if (prev_fill_ff < slots) begin
               miss_acc = {1'b0, slots - prev_fill_ff};
            end
            released_in = 1'b1;
         end
         if (cur_fill_ff == slots) begin
            retired_in   = 1'b1;
            prev_vld_in  = 1'b0;
            prev_fill_in = '0;
         end else begin
            prev_vld_in  = 1'b1;
            prev_fill_in = cur_fill_ff;
         end
         pos_in      = '0;
         cur_fill_in = '0;
         ws_in       = ws_p1;
      end

      ds        = signed'(seq - ws_in);
      jump_pos  = ds[CNT_W-1:0] - slots;
      late_slot = slots + ds[CNT_W-1:0];

      if (!started_ff) begin
         // first packet opens the window
         started_in  = 1'b1;
         last_in     = seq;
         ws_in       = seq;
         cur_fill_in = fill_inc(cur_fill_in);
         slot_in     = pos_in[SLOT_W-1:0];
         pos_in      = pos_in + 17'd1;
         place_in    = PLACE_CURRENT;
      end else if (seq == last_p1) begin
         last_in     = seq;
         cur_fill_in = fill_inc(cur_fill_in);
         slot_in     = pos_in[SLOT_W-1:0];
         pos_in      = pos_in + 17'd1;
         place_in    = PLACE_CURRENT;
      end else if (seq == last_ff) begin
         place_in = PLACE_DUPLICATE;
      end else if (dc < 0) begin
         if (ds < 0) begin
            if (!prev_vld_in || ds < neg_s) begin
               miss_acc = miss_acc + 18'd1;
            end else begin
               // late packet into the previous buffer
               prev_fill_in = fill_inc(prev_fill_in);
               slot_in      = late_slot[SLOT_W-1:0];
               place_in     = PLACE_PREVIOUS;
               if (prev_fill_in >= slots) begin
                  released_in  = 1'b1;
                  prev_vld_in  = 1'b0;
                  prev_fill_in = '0;
               end
            end
         end else if (ds >= s64) begin
            miss_acc = miss_acc + 18'd1;
         end else begin
            cur_fill_in = fill_inc(cur_fill_in);
            slot_in     = ds[SLOT_W-1:0];
            place_in    = PLACE_CURRENT;
         end
      end else begin
         if (ds >= s64) begin
            if (ds >= two_s) begin
               miss_acc = miss_acc + 18'd1;
            end else begin
               // jump into the next buffer: a further advance
               adv_in = 1'b1;
               if (prev_vld_in) begin
                  if (prev_fill_in < slots) begin
                     miss_acc = miss_acc + {1'b0, slots - prev_fill_in};
                  end
                  released_in = 1'b1;
               end
               if (cur_fill_in == slots) begin
                  retired_in   = 1'b1;
                  prev_vld_in  = 1'b0;
                  prev_fill_in = '0;
               end else begin
                  prev_vld_in  = 1'b1;
                  prev_fill_in = cur_fill_in;
               end
               ws_in       = adv_first ? ws_p2 : ws_p1;
               cur_fill_in = fill_inc('0);
               last_in     = seq;
               pos_in      = jump_pos + 17'd1;
               slot_in     = jump_pos[SLOT_W-1:0];
               place_in    = PLACE_CURRENT;
            end
         end else if (ds < 0) begin
            miss_acc = miss_acc + 18'd1;
         end else begin
            // skip ahead inside the window
            cur_fill_in = fill_inc(cur_fill_in);
            slot_in     = ds[SLOT_W-1:0];
            pos_in      = ds[CNT_W-1:0] + 17'd1;
            last_in     = seq;
            place_in    = PLACE_CURRENT;
         end
      end

      missing_in = (miss_acc > {1'b0, FILL_MAX}) ? FILL_MAX : miss_acc[CNT_W-1:0];
   end

   // ---------------- control and state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_cfg_ff <= SLOTS_RESET;
         mode_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         last_ff      <= '0;
         ws_ff        <= '0;
         pos_ff       <= '0;
         cur_fill_ff  <= '0;
         prev_vld_ff  <= 1'b0;
         prev_fill_ff <= '0;
      end else begin
         if (csr_write) begin
            case (paddr[2])
               CSR_IDX_SLOTS: slots_cfg_ff <= pwdata[CNT_W-1:0];
               CSR_IDX_MODE:  mode_ff      <= pwdata[0];
               default: ;
            endcase
         end

         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end

         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (fire) begin
            started_ff   <= started_in;
            last_ff      <= last_in;
            ws_ff        <= ws_in;
            pos_ff       <= pos_in;
            cur_fill_ff  <= cur_fill_in;
            prev_vld_ff  <= prev_vld_in;
            prev_fill_ff <= prev_fill_in;
         end
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_seq_ff <= req_seq_number;
      end
      if (fire) begin
         place_ff    <= place_in;
         slot_ff     <= slot_in;
         adv_ff      <= adv_in;
         retired_ff  <= retired_in;
         released_ff <= released_in;
         missing_ff  <= missing_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_placement         = place_ff;
   assign rsp_slot_index        = slot_ff;
   assign rsp_window_advanced   = adv_ff;
   assign rsp_retired_complete  = retired_ff;
   assign rsp_previous_released = released_ff;
   assign rsp_missing_added     = missing_ff;

endmodule

`default_nettype wire

// ===== sv/prw_checker.sv =====
// ---------------------------------------------------------------------------
// prw_checker
// Port-level checks for the packet resequencer window core, bound to it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "packet_resequencer_window_core_assert.svh"

module prw_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_stall,
   input wire                                 rsp_valid,
   input wire                                 rsp_stall,
   input prw_pkg::placement_type              rsp_placement,
   input wire  [prw_pkg::SLOT_W-1:0]          rsp_slot_index,
   input wire                                 rsp_window_advanced,
   input wire                                 rsp_retired_complete,
   input wire  [prw_pkg::CNT_W-1:0]           rsp_missing_added
);
   import prw_pkg::*;

   // a stalled result word holds
   `PRW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_placement) && $stable(rsp_slot_index) && $stable(rsp_missing_added))

   // with the result register empty, the input side never stalls
   `PRW_ASSERT_SAME(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // dropped packets carry slot zero
   `PRW_ASSERT_SAME(a_drop_slot_zero, clock, reset, rsp_valid && (rsp_placement == PLACE_DUPLICATE || rsp_placement == PLACE_OUT_OF_WINDOW), rsp_slot_index == '0)

   // missing packets come only from a flush or an out-of-window drop
   `PRW_ASSERT_SAME(a_missing_source, clock, reset, rsp_valid && rsp_missing_added != '0, rsp_window_advanced || rsp_placement == PLACE_OUT_OF_WINDOW)

   // a full buffer is retired only when the window moves
   `PRW_ASSERT_SAME(a_retire_on_advance, clock, reset, rsp_valid && rsp_retired_complete, rsp_window_advanced)

endmodule

bind packet_resequencer_window_core prw_checker u_prw_checker (.*);

`default_nettype wire

// ===== tb/packet_resequencer_window_core_tb.sv =====
// ---------------------------------------------------------------------------
// packet_resequencer_window_core_tb
// Drives sequence numbers into the resequencer window and checks every
// placement word against a cycle-free model of the two-buffer window, with
// random idle on the request side and random stall on the result side.
// ---------------------------------------------------------------------------
module packet_resequencer_window_core_tb;
   import prw_pkg::*;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int TIMEOUT       = 4_000_000;
   localparam int SETTLE_CYCLES = 6;    // two-stage pipe plus margin
   localparam int MAX_REPORTS   = 10;
   localparam int CHUNK_WORDS   = 42;
   localparam int CHUNKS        = 4;

   // one expected result word
   typedef struct {
      placement_type       placement;
      logic [SLOT_W-1:0]   slot_index;
      logic                window_advanced;
      logic                retired_complete;
      logic                previous_released;
      logic [CNT_W-1:0]    missing_added;
   } placement_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid;
   logic                    req_stall;
   logic [SEQ_W-1:0]        req_seq_number;
   logic                    rsp_valid;
   logic                    rsp_stall;
   placement_type           rsp_placement;
   logic [SLOT_W-1:0]       rsp_slot_index;
   logic                    rsp_window_advanced;
   logic                    rsp_retired_complete;
   logic                    rsp_previous_released;
   logic [CNT_W-1:0]        rsp_missing_added;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   // idle shaping, percent of cycles
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   int unsigned        mismatch_count = 0;
   placement_word_type pending_placements[$];

   // window model: configuration
   logic [CNT_W-1:0] slots_cfg = SLOTS_RESET;
   logic             mode_cfg  = 1'b0;
   // window model: state
   bit               win_opened = 1'b0;
   longint unsigned  last_seq   = 0;
   longint unsigned  win_start  = 0;
   int unsigned      slot_pos   = 0;
   int unsigned      cur_fill   = 0;
   bit               prev_open  = 1'b0;
   int unsigned      prev_fill  = 0;
   // per-word flags, built up while the word is placed
   bit               adv_f, ret_f, rel_f;
   int unsigned      miss_acc;

   packet_resequencer_window_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_seq_number        (req_seq_number),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_placement         (rsp_placement),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_window_advanced   (rsp_window_advanced),
      .rsp_retired_complete  (rsp_retired_complete),
      .rsp_previous_released (rsp_previous_released),
      .rsp_missing_added     (rsp_missing_added),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always #CLK_HALF clock = ~clock;

   initial begin
      #TIMEOUT;
      $display("packet_resequencer_window_core verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Window model
   // -------------------------------------------------------------------------
   function automatic int unsigned bump_fill(int unsigned f);
      return (f < FILL_MAX) ? f + 1 : FILL_MAX;
   endfunction

   // move to the next buffer: flush the previous one (its holes count as
   // missing), then either retire the current one if full or keep it open
   // as the new previous buffer
   function automatic void shift_window(int unsigned slots);
      adv_f = 1'b1;
      if (prev_open) begin
         if (prev_fill < slots)
            miss_acc += slots - prev_fill;
         rel_f     = 1'b1;
         prev_open = 1'b0;
         prev_fill = 0;
      end
      if (cur_fill == slots) begin
         ret_f     = 1'b1;
         prev_open = 1'b0;
         prev_fill = 0;
      end else begin
         prev_open = 1'b1;
         prev_fill = cur_fill;
      end
      slot_pos  = 0;
      cur_fill  = 0;
      win_start += slots;
   endfunction

   function automatic placement_word_type place_packet(logic [SEQ_W-1:0] seq_in);
      placement_word_type r;
      longint unsigned seq;
      longint          dc, ds, s, slot_sel;
      int unsigned     slots;
      slots = slots_cfg;
      if (slots < 1) slots = 1;
      if (slots > MAX_SLOTS) slots = MAX_SLOTS;
      s        = slots;
      slot_sel = 0;
      adv_f    = 1'b0;
      ret_f    = 1'b0;
      rel_f    = 1'b0;
      miss_acc = 0;
      r.placement = PLACE_OUT_OF_WINDOW;

      // buffer switch happens ahead of placement
      if (slot_pos >= slots)
         shift_window(slots);

      // implied-sequence mode ignores the carried number
      seq = mode_cfg ? last_seq + 1 : {1'b0, seq_in};

      if (!win_opened) begin
         // first word opens the window at slot 0
         win_opened  = 1'b1;
         last_seq    = seq;
         win_start   = seq;
         cur_fill    = bump_fill(cur_fill);
         slot_sel    = slot_pos;
         slot_pos++;
         r.placement = PLACE_CURRENT;
      end else if (seq == last_seq + 1) begin
         last_seq    = seq;
         cur_fill    = bump_fill(cur_fill);
         slot_sel    = slot_pos;
         slot_pos++;
         r.placement = PLACE_CURRENT;
      end else if (seq == last_seq) begin
         r.placement = PLACE_DUPLICATE;
      end else begin
         dc = $signed(seq - last_seq);
         ds = $signed(seq - win_start);
         if (dc < 0) begin
            if (ds < 0) begin
               if (!prev_open || ds < -s) begin
                  miss_acc++;              // too late for any open buffer
               end else begin
                  prev_fill   = bump_fill(prev_fill);
                  slot_sel    = s + ds;
                  r.placement = PLACE_PREVIOUS;
                  if (prev_fill >= slots) begin
                     rel_f     = 1'b1;     // late word completed it
                     prev_open = 1'b0;
                     prev_fill = 0;
                  end
               end
            end else if (ds >= s) begin
               miss_acc++;                 // stale position
            end else begin
               cur_fill    = bump_fill(cur_fill);
               slot_sel    = ds;
               r.placement = PLACE_CURRENT;
            end
         end else begin
            if (ds >= s) begin
               if (ds >= 2 * s) begin
                  miss_acc++;              // far ahead
               end else begin
                  // jump into the next buffer
                  shift_window(slots);
                  cur_fill    = bump_fill(cur_fill);
                  last_seq    = seq;
                  slot_sel    = ds - s;
                  slot_pos    = slot_sel + 1;
                  r.placement = PLACE_CURRENT;
               end
            end else if (ds < 0) begin
               miss_acc++;
            end else begin
               // skip ahead inside the window
               cur_fill    = bump_fill(cur_fill);
               slot_sel    = ds;
               slot_pos    = ds + 1;
               last_seq    = seq;
               r.placement = PLACE_CURRENT;
            end
         end
      end

      if (miss_acc > FILL_MAX)
         miss_acc = FILL_MAX;
      r.slot_index        = slot_sel[SLOT_W-1:0];
      r.window_advanced   = adv_f;
      r.retired_complete  = ret_f;
      r.previous_released = rel_f;
      r.missing_added     = miss_acc[CNT_W-1:0];
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Result side: random stall, compare each accepted word with the oldest
   // expectation
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      placement_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_placements.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word: placement %s slot %0d",
                        rsp_placement.name(), rsp_slot_index);
         end else begin
            exp_w = pending_placements.pop_front();
            if (rsp_placement !== exp_w.placement ||
                rsp_slot_index !== exp_w.slot_index ||
                rsp_window_advanced !== exp_w.window_advanced ||
                rsp_retired_complete !== exp_w.retired_complete ||
                rsp_previous_released !== exp_w.previous_released ||
                rsp_missing_added !== exp_w.missing_added) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("result mismatch: expected place %s slot %0d adv %b ret %b rel %b miss %0d",
                           exp_w.placement.name(), exp_w.slot_index,
                           exp_w.window_advanced, exp_w.retired_complete,
                           exp_w.previous_released, exp_w.missing_added);
                  $display("                 actual   place %s slot %0d adv %b ret %b rel %b miss %0d",
                           rsp_placement.name(), rsp_slot_index, rsp_window_advanced,
                           rsp_retired_complete, rsp_previous_released,
                           rsp_missing_added);
               end
            end
         end
      end
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   // -------------------------------------------------------------------------
   // Request side and register helpers; all entered and left at a rising edge
   // -------------------------------------------------------------------------

   // send one word; the expectation is formed at the edge that takes it
   task automatic send_word(logic [SEQ_W-1:0] seq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_seq_number <= seq;
      do @(posedge clock); while (req_stall);
      pending_placements.push_back(place_packet(seq));
   endtask

   // hold the request side until every result word is back, then let the
   // pipe settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write a register, then read it back
   task automatic set_register(logic idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      readback = (idx == CSR_IDX_SLOTS) ? {15'd0, value[CNT_W-1:0]} : {31'd0, value[0]};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_IDX_SLOTS)
         slots_cfg = value[CNT_W-1:0];
      else
         mode_cfg = value[0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== readback) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("register %0d readback: expected %h actual %h", idx, readback, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // sequence number relative to the model's last one, kept in field range
   function automatic logic [SEQ_W-1:0] seq_near_last(longint off);
      longint unsigned v;
      v = last_seq + off;
      if (&v[SEQ_W-1:0]) v = v - 1;
      return v[SEQ_W-1:0];
   endfunction

   // mostly well-formed traffic: in order, reordered, duplicated, skips and
   // jumps around the window; a little noise over the whole field
   function automatic logic [SEQ_W-1:0] pick_sequence();
      int unsigned s, r;
      longint unsigned v;
      s = (slots_cfg == 0) ? 1 : (slots_cfg > MAX_SLOTS) ? MAX_SLOTS : slots_cfg;
      r = $urandom_range(0, 99);
      if (r < 50)
         return seq_near_last(1);
      else if (r < 62)
         return seq_near_last(-longint'($urandom_range(1, 2 * s)));
      else if (r < 70)
         return seq_near_last(0);
      else if (r < 80)
         return seq_near_last($urandom_range(2, s + 1));
      else if (r < 86)
         return seq_near_last(longint'(win_start - last_seq) + $urandom_range(s, 3 * s));
      else if (r < 92)
         return seq_near_last(longint'(win_start - last_seq) - $urandom_range(0, 2 * s + 1));
      v = {$urandom, $urandom};
      if (&v[SEQ_W-1:0]) v = v - 1;
      return v[SEQ_W-1:0];
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // window opening, in-order, duplicate, skip, late, field extremes
   task automatic test_window_open();
      set_register(CSR_IDX_SLOTS, 32'h10000);
      set_register(CSR_IDX_MODE, 32'd0);
      send_word(63'd1000);                   // opens the window
      send_word(63'd1001);
      send_word(63'd1001);                   // duplicate
      send_word(63'd1003);                   // skip ahead
      send_word(63'd1002);                   // late, current buffer
      send_word(63'd0);                      // before the window
      send_word(63'h7fff_ffff_ffff_fffe);    // far ahead, top of range
      drain_results();
   endtask

   // small buffers: full retire, jump into next buffer, late previous,
   // far-ahead drop
   task automatic test_buffer_switch();
      longint offs[10] = '{1, 1, 1, 1, 3, -1, 0, 4, -6, 9};
      set_register(CSR_IDX_SLOTS, 32'd4);
      foreach (offs[k])
         send_word(seq_near_last(offs[k]));
      drain_results();
   endtask

   // size register extremes, both clamped
   task automatic test_slot_extremes();
      longint tiny_offs[4] = '{1, 1, -1, 2};
      set_register(CSR_IDX_SLOTS, 32'd0);
      foreach (tiny_offs[k])
         send_word(seq_near_last(tiny_offs[k]));
      drain_results();
      set_register(CSR_IDX_SLOTS, 32'h1ffff);
      send_word(seq_near_last(1));
      send_word(seq_near_last(65536));
      drain_results();
   endtask

   // implied sequence: the carried number is ignored
   task automatic test_implied_sequence();
      set_register(CSR_IDX_SLOTS, 32'd3);
      set_register(CSR_IDX_MODE, 32'd1);
      send_word(63'h7fff_ffff_ffff_fffe);
      send_word('0);
      send_word(63'h2aaa_aaaa_aaaa_aaaa);
      send_word(63'h5555_5555_5555_5555);
      drain_results();
      set_register(CSR_IDX_MODE, 32'd0);
   endtask

   // random traffic in chunks; sizes and mode change between chunks
   task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
      int unsigned pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int c = 0; c < CHUNKS; c++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)
            set_register(CSR_IDX_SLOTS, 32'h10000);
         else if (pick < 7)
            set_register(CSR_IDX_SLOTS, 32'h1ffff);
         else if (pick < 10)
            set_register(CSR_IDX_SLOTS, 32'd0);
         else
            set_register(CSR_IDX_SLOTS, $urandom_range(1, 12));
         set_register(CSR_IDX_MODE, ($urandom_range(0, 9) == 0) ? 32'd1 : 32'd0);
         for (int n = 0; n < CHUNK_WORDS; n++) begin
            send_word(pick_sequence());
            // occasional full drain mid-stream
            if ($urandom_range(0, 99) == 0)
               drain_results();
         end
         drain_results();
      end
   endtask

   initial begin
      req_valid      <= 1'b0;
      req_seq_number <= '0;
      rsp_stall      <= 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_window_open();
      test_buffer_switch();
      test_slot_extremes();
      test_implied_sequence();
      test_random_traffic(24, 57);
      test_random_traffic(57, 24);
      test_random_traffic(0, 0);

      req_valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("packet_resequencer_window_core verification clean");
      else
         $display("packet_resequencer_window_core verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/prw_pkg.sv
sv/packet_resequencer_window_core.sv
sv/prw_checker.sv
tb/packet_resequencer_window_core_tb.sv
